@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the RTL of the SHA-1 engine.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition at one edge is followed by a consequence at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sha1_pkg.sv @@
// Types and constants for the SHA-1 hash engine.
// No dependencies; used by sha1_hash_engine by scoped names.
`default_nettype none

package sha1_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIN,
    ST_PREP,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  // Kind of block currently being compressed
  typedef enum logic [1:0] {
    BLK_DATA,    // full block of message bytes
    BLK_PAD,     // message tail plus pad byte, no room for length
    BLK_PADLEN,  // message tail plus pad byte and length
    BLK_LEN      // zeros and length only
  } blk_t;

  localparam int unsigned NUM_WORDS = 5;

  localparam logic [31:0] H_INIT [0:NUM_WORDS-1] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [5:0] BLOCK_END   = 6'd63;
  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [6:0] ROUND_20    = 7'd20;
  localparam logic [6:0] ROUND_40    = 7'd40;
  localparam logic [6:0] ROUND_60    = 7'd60;
  localparam logic [3:0] LEN_WORD_HI = 4'd14;
  localparam logic [2:0] LAST_WORD   = 3'd4;

endpackage

`default_nettype wire

@@ hw/rtl/sha1_hash_engine.sv @@
// SHA-1 hash engine: byte stream in, five 32-bit digest words out.
// Depends on sha1_pkg and assert_macros.svh.
//
//   channel | ports                        | content
//   in      | in_tvalid/in_tready          | tdata: data_byte; tlast: last; tuser: no_byte
//   out     | out_tvalid/out_tready        | tdata: digest_word; tuser: word_index;
//           |                              | tlast: last_word
//
// A byte is taken while idle. A byte that fills a block adds a block pass (load, 80 rounds of
// the single shared round adder, fold into chaining words). A last item adds a finish step
// plus one or two such blocks, then five output transfers, one per cycle at best.
// Sustained throughput is set by the one-round-per-cycle adder; no byte is taken during a pass.
// Reset loads the initial chaining words and clears the byte count; no clearing pass.
// Output words hold while out_tready is low; input is not taken until all are sent.
`default_nettype none
`include "assert_macros.svh"

module sha1_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,
  input  wire logic [0:0]  in_tuser,   // [0] no_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic [2:0]       out_tuser,  // [2:0] word_index
  output logic             out_tlast
);

  sha1_pkg::state_t state_r, state_nxt;
  sha1_pkg::blk_t   blk_r;
  logic             fin_r;
  logic [63:0]      byte_count_r;
  logic [31:0]      h_r [0:sha1_pkg::NUM_WORDS-1];
  logic [31:0]      a_r, b_r, c_r, d_r, e_r;
  logic [31:0]      win_r [0:15];
  logic [6:0]       rnd_r;
  logic [2:0]       widx_r;

  // Block buffer: 16 big-endian words, byte-lane writes
  logic [31:0]      mem [0:15];
  logic [31:0]      mem_rd_r;
  logic [3:0]       mem_raddr;

  logic [5:0]       pos;
  logic             in_xfer;
  logic             take;
  logic [63:0]      len_bits;
  logic [31:0]      blk_word;
  logic [31:0]      sched_x;
  logic [31:0]      w;
  logic [31:0]      f;
  logic [31:0]      k;
  logic [31:0]      t;

  assign pos     = byte_count_r[5:0];
  assign in_xfer = in_tvalid & in_tready;
  assign take    = in_xfer & ~in_tuser[0];

  // Padded bit length, all ones once the count reaches 2^61 bytes
  assign len_bits = (|byte_count_r[63:61]) ? '1 : {byte_count_r[60:0], 3'b000};

  // Write the incoming byte into its lane, read one word a cycle during a block
  always_ff @(posedge clk) begin
    if (take) begin
      mem[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= in_tdata;
    end
    mem_rd_r <= mem[mem_raddr];
  end

  // Form the message word for rounds 0..15, applying padding and length
  always_comb begin
    logic [5:0] j;
    j        = '0;
    blk_word = mem_rd_r;
    for (int i = 0; i < 4; i++) begin
      j = {rnd_r[3:0], i[1:0]};
      if (blk_r == sha1_pkg::BLK_LEN) begin
        blk_word[(3 - i) * 8 +: 8] = 8'h00;
      end else if (blk_r != sha1_pkg::BLK_DATA) begin
        if (j == pos) begin
          blk_word[(3 - i) * 8 +: 8] = sha1_pkg::PAD_BYTE;
        end else if (j > pos) begin
          blk_word[(3 - i) * 8 +: 8] = 8'h00;
        end
      end
    end
    if ((blk_r == sha1_pkg::BLK_PADLEN || blk_r == sha1_pkg::BLK_LEN) &&
        rnd_r[3:0] >= sha1_pkg::LEN_WORD_HI) begin
      blk_word = rnd_r[0] ? len_bits[31:0] : len_bits[63:32];
    end
  end

  // Shared round unit: schedule word, round function, five-operand add
  always_comb begin
    sched_x = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
    w       = (rnd_r[6:4] == 3'd0) ? blk_word : {sched_x[30:0], sched_x[31]};
    if (rnd_r < sha1_pkg::ROUND_20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = sha1_pkg::K_R0;
    end else if (rnd_r < sha1_pkg::ROUND_40) begin
      f = b_r ^ c_r ^ d_r;
      k = sha1_pkg::K_R1;
    end else if (rnd_r < sha1_pkg::ROUND_60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = sha1_pkg::K_R2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = sha1_pkg::K_R3;
    end
    t = {a_r[26:0], a_r[31:27]} + f + e_r + k + w;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (take && pos == sha1_pkg::BLOCK_END) begin
            state_nxt = sha1_pkg::ST_PREP;
          end else if (in_tlast) begin
            state_nxt = sha1_pkg::ST_FIN;
          end
        end
      end
      sha1_pkg::ST_FIN:   state_nxt = sha1_pkg::ST_PREP;
      sha1_pkg::ST_PREP:  state_nxt = sha1_pkg::ST_ROUND;
      sha1_pkg::ST_ROUND: begin
        if (rnd_r == sha1_pkg::LAST_ROUND) begin
          state_nxt = sha1_pkg::ST_FOLD;
        end
      end
      sha1_pkg::ST_FOLD: begin
        case (blk_r)
          sha1_pkg::BLK_DATA: state_nxt = fin_r ? sha1_pkg::ST_FIN : sha1_pkg::ST_IDLE;
          sha1_pkg::BLK_PAD:  state_nxt = sha1_pkg::ST_PREP;
          default:            state_nxt = sha1_pkg::ST_OUT;
        endcase
      end
      sha1_pkg::ST_OUT: begin
        if (out_tready && widx_r == sha1_pkg::LAST_WORD) begin
          state_nxt = sha1_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha1_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    mem_raddr  = rnd_r[3:0] + 4'd1;
    case (state_r)
      sha1_pkg::ST_IDLE: in_tready  = 1'b1;
      sha1_pkg::ST_PREP: mem_raddr  = '0;
      sha1_pkg::ST_OUT:  out_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign out_tdata = h_r[widx_r];
  assign out_tuser = widx_r;
  assign out_tlast = (widx_r == sha1_pkg::LAST_WORD);

  // Control state, byte count and chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sha1_pkg::ST_IDLE;
      blk_r        <= sha1_pkg::BLK_DATA;
      fin_r        <= 1'b0;
      byte_count_r <= '0;
      rnd_r        <= '0;
      widx_r       <= '0;
      h_r          <= sha1_pkg::H_INIT;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        sha1_pkg::ST_IDLE: begin
          if (in_xfer) begin
            // Saturate the count at all ones
            if (take && byte_count_r != '1) begin
              byte_count_r <= byte_count_r + 64'd1;
            end
            fin_r <= in_tlast;
            blk_r <= sha1_pkg::BLK_DATA;
          end
        end
        sha1_pkg::ST_FIN: begin
          blk_r <= (pos >= sha1_pkg::LEN_POS) ? sha1_pkg::BLK_PAD : sha1_pkg::BLK_PADLEN;
        end
        sha1_pkg::ST_PREP:  rnd_r <= '0;
        sha1_pkg::ST_ROUND: rnd_r <= rnd_r + 7'd1;
        sha1_pkg::ST_FOLD: begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
          widx_r <= '0;
          if (blk_r == sha1_pkg::BLK_PAD) begin
            blk_r <= sha1_pkg::BLK_LEN;
          end
        end
        sha1_pkg::ST_OUT: begin
          if (out_tready) begin
            widx_r <= widx_r + 3'd1;
            // Return to the initial state after the final word
            if (widx_r == sha1_pkg::LAST_WORD) begin
              h_r          <= sha1_pkg::H_INIT;
              byte_count_r <= '0;
              fin_r        <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working variables and schedule window
  always_ff @(posedge clk) begin
    if (state_r == sha1_pkg::ST_PREP) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (state_r == sha1_pkg::ST_ROUND) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[15] <= w;
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_excl_hs, clk, rst_n, !(in_tready && out_tvalid), "ready while digest pending")
  `ASSERT_NEXT(a_last_busy, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready, "last item not finished")
  `ASSERT_NEXT(a_end_clear, clk, rst_n, out_tvalid && out_tready && out_tlast, in_tready && byte_count_r == '0, "no return to initial state")

endmodule

`default_nettype wire

@@ test/sha1_hash_engine_tb.sv @@
// Self-checking testbench for sha1_hash_engine: byte stream in, digest words out.
// Depends on sha1_pkg and the engine RTL; an internal SHA-1 predictor supplies the
// expected digest words, checked in order against every output transfer.
`timescale 1ns / 1ps

module sha1_hash_engine_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_ITEMS     = 50;
  localparam int LONG_HOLD      = 300;
  localparam int TOTAL_ITEMS    = 310;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       no_byte;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;
  logic [0:0]  in_tuser;   // [0] no_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] digest_word
  logic [2:0]  out_tuser;  // [2:0] word_index
  logic        out_tlast;

  // Stimulus and expectation stores
  msg_item_t    msg_feed_q[$];
  digest_beat_t digest_expect_q[$];

  // Predictor state
  logic [31:0] chain_h [0:4];
  logic [63:0] msg_len;
  logic [7:0]  blk [0:63];

  // Bookkeeping
  int   items_total;
  int   items_sent;
  int   items_in;
  int   bytes_taken;
  int   msgs_done;
  int   words_checked;
  int   longest_msg;
  int   idle_cycles;
  int   in_gap;
  int   out_gap;
  int   hold_left;
  bit   hold_used;
  bit   failed;
  logic in_xfer;
  msg_item_t drv_item;

  wire tail_phase = (items_sent + TAIL_ITEMS >= items_total);

  sha1_hash_engine DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // One 80-round compression of the current block into the chaining words
  function automatic void sha1_compress();
    logic [31:0] w [0:15];
    logic [31:0] a, b, c, d, e, f, k, t;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 16; r++)
      w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
    for (int r = 0; r < 80; r++) begin
      if (r >= 16)
        w[r % 16] = rotl32(w[(r-3) % 16] ^ w[(r-8) % 16] ^ w[(r-14) % 16] ^ w[r % 16], 1);
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1_pkg::K_R0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1_pkg::K_R1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_pkg::K_R2;
      end else begin
        f = b ^ c ^ d;
        k = sha1_pkg::K_R3;
      end
      t = rotl32(a, 5) + f + e + k + w[r % 16];
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void sha1_restart();
    chain_h = sha1_pkg::H_INIT;
    msg_len = '0;
  endfunction

  // Store one byte at the fill position; the count saturates
  function automatic void sha1_absorb_byte(input logic [7:0] v);
    logic [5:0] pos;
    pos = msg_len[5:0];
    blk[pos] = v;
    if (msg_len != '1)
      msg_len++;
    if (pos == sha1_pkg::BLOCK_END)
      sha1_compress();
  endfunction

  // Pad, append bit length, queue the five digest words, start over
  function automatic void sha1_finish_digest();
    logic [5:0]   pos;
    logic [63:0]  bits;
    digest_beat_t beat;
    pos  = msg_len[5:0];
    bits = (msg_len >= 64'h2000_0000_0000_0000) ? '1 : {msg_len[60:0], 3'b000};
    blk[pos] = sha1_pkg::PAD_BYTE;
    for (int i = int'(pos) + 1; i < 64; i++)
      blk[i] = 8'h00;
    if (pos >= sha1_pkg::LEN_POS) begin
      sha1_compress();
      for (int i = 0; i < 64; i++)
        blk[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++)
      blk[56 + i] = bits[63 - 8*i -: 8];
    sha1_compress();
    for (int i = 0; i < 5; i++) begin
      beat.digest_word = chain_h[i];
      beat.word_index  = i[2:0];
      beat.last_word   = (i[2:0] == sha1_pkg::LAST_WORD);
      digest_expect_q.push_back(beat);
    end
    sha1_restart();
  endfunction

  task automatic push_item(input logic [7:0] data_byte, input bit last, input bit no_byte);
    msg_item_t it;
    it.data_byte = data_byte;
    it.last      = last;
    it.no_byte   = no_byte;
    msg_feed_q.push_back(it);
  endtask

  // Sender: offer the next item once the current one has moved
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_xfer) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (msg_feed_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 6);
        in_tvalid <= 1'b0;
      end else begin
        drv_item = msg_feed_q.pop_front();
        in_tdata  <= drv_item.data_byte;
        in_tlast  <= drv_item.last;
        in_tuser  <= drv_item.no_byte;
        in_tvalid <= 1'b1;
        items_sent++;
      end
    end
  end

  // Receiver: random bursts of back-pressure, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_used && items_in >= 80) begin
      hold_used = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Predict on every input transfer, check every output transfer
  always @(posedge clk) begin
    in_xfer <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      items_in++;
      if (!in_tuser[0]) begin
        sha1_absorb_byte(in_tdata);
        bytes_taken++;
      end
      if (in_tlast) begin
        if (int'(msg_len) > longest_msg)
          longest_msg = int'(msg_len);
        sha1_finish_digest();
        msgs_done++;
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_expect_q.size() == 0) begin
        $error("unexpected digest transfer: word %h index %0d last %b",
               out_tdata, out_tuser, out_tlast);
        failed = 1'b1;
      end else begin
        digest_beat_t exp_beat;
        exp_beat = digest_expect_q.pop_front();
        words_checked++;
        if (out_tdata !== exp_beat.digest_word) begin
          $error("digest_word: expected %h, got %h", exp_beat.digest_word, out_tdata);
          failed = 1'b1;
        end
        if (out_tuser !== exp_beat.word_index) begin
          $error("word_index: expected %0d, got %0d", exp_beat.word_index, out_tuser);
          failed = 1'b1;
        end
        if (out_tlast !== exp_beat.last_word) begin
          $error("last_word: expected %b, got %b", exp_beat.last_word, out_tlast);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      idle_cycles = 0;
    else if (rst_n)
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
      $display("sha1_hash_engine_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int boundary_len [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
    int len;
    bit last_alone;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tlast    = 1'b0;
    in_tuser    = 1'b0;
    out_tready  = 1'b0;
    in_xfer     = 1'b0;
    items_total = 0;
    items_sent  = 0;
    items_in    = 0;
    bytes_taken = 0;
    msgs_done   = 0;
    words_checked = 0;
    longest_msg = 0;
    idle_cycles = 0;
    in_gap      = 0;
    out_gap     = 0;
    hold_left   = 0;
    hold_used   = 1'b0;
    failed      = 1'b0;
    sha1_restart();

    // Directed: empty message, "abc", ignored items, byte values at the extremes
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'h61, 1'b0, 1'b0);
    push_item(8'h62, 1'b0, 1'b0);
    push_item(8'h63, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'hA5, 1'b0, 1'b1);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'h5A, 1'b1, 1'b1);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);
    push_item(8'h5A, 1'b1, 1'b0);
    push_item(8'h3C, 1'b0, 1'b1);
    push_item(8'hC3, 1'b1, 1'b1);

    // Random messages: mostly short, some on the padding and block boundaries
    while (msg_feed_q.size() < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) < 7)
        len = $urandom_range(0, 6);
      else
        len = boundary_len[$urandom_range(0, 7)];
      // Trim the final message to the remaining item budget
      if (len > TOTAL_ITEMS - msg_feed_q.size())
        len = TOTAL_ITEMS - msg_feed_q.size();
      last_alone = (len == 0) || $urandom_range(0, 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0)
          push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        push_item(8'($urandom_range(0, 255)), (i == len - 1) && !last_alone, 1'b0);
      end
      if (last_alone)
        push_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end
    items_total = msg_feed_q.size();

    // Hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain: stimulus, then expectations, then settle time
    while (msg_feed_q.size() != 0 || in_tvalid)
      @(posedge clk);
    while (digest_expect_q.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d messages (%0d bytes, longest %0d) over %0d input transfers",
             msgs_done, bytes_taken, longest_msg, items_in);
    $display("checked %0d digest words, including a long output hold-off", words_checked);
    if (!failed)
      $display("sha1_hash_engine_tb: PASS");
    else
      $display("sha1_hash_engine_tb: FAIL");
    $finish;
  end

endmodule
